// ----- rtl/core/zz3_pkg.sv -----
// ----------------------------------------------------------------------------
// zz3_pkg: shared types and constants of the 3D zigzag index generator
// Word widths, register indexes, queue depths and the control structs that
// pass between the front queue, the walker, the index unit and the result
// queue.
// ----------------------------------------------------------------------------
package zz3_pkg;

    localparam int MAX_DIM_DEF = 256;
    localparam int CFG_W       = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int IDX_W       = 25;
    localparam int CQ_DEPTH    = 2;
    localparam int RQ_DEPTH    = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIM_X = 2'd0,
        CFG_DIM_Y = 2'd1,
        CFG_DIM_Z = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        DIR_FWD = 1'b0,
        DIR_BWD = 1'b1
    } dir_t;

    typedef enum logic {
        CMD_NEXT    = 1'b0,
        CMD_RESTART = 1'b1
    } cmd_kind_t;

    typedef enum logic {
        W_IDLE = 1'b0,
        W_WALK = 1'b1
    } walk_state_t;

    typedef struct packed {
        logic      valid;
        cmd_kind_t kind;
    } cmd_t;

    typedef struct packed {
        logic valid;
        logic blank;
        logic last;
    } cand_ctrl_t;

    typedef struct packed {
        logic             valid;
        logic             last;
        logic [IDX_W-1:0] index;
    } res_t;

endpackage

// ----- rtl/core/zigzag_3d_index_generator.sv -----
// ----------------------------------------------------------------------------
// zigzag_3d_index_generator: 3D zigzag scan index generator
// Streams the zigzag scan order of an X by Y by Z volume as 1-based linear
// indices, one result word for each request word.
//
//   channel   direction  handshake            payload
//   request   in         push / full          restart
//   result    out        empty / pop          linear_index, last
//   config    in         cfg_we (no wait)     cfg_index, cfg_data
//
// For each request the walk sequencer skips the out-of-bounds candidates
// before the next in-bounds one; it examines one candidate per cycle and
// sets the rate. The index pipeline holds the word in its s1 and result
// registers before the word reaches the queue.
// Reset sets all dimensions to 1, empties both queues and restarts the walk.
// A full result queue holds back the walker; requests still queue in front.
// ----------------------------------------------------------------------------
module zigzag_3d_index_generator
#(
    parameter int MAX_DIM = zz3_pkg::MAX_DIM_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [zz3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [zz3_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           push,
    input  logic                           restart,
    output logic                           full,
    output logic                           empty,
    input  logic                           pop,
    output logic [zz3_pkg::IDX_W-1:0]      linear_index,
    output logic                           last
);

    localparam int DW  = $clog2(MAX_DIM + 1);
    localparam int CLW = (DW > zz3_pkg::CFG_W) ? DW : zz3_pkg::CFG_W;

    logic [zz3_pkg::CFG_W-1:0] dim_x_reg;
    logic [zz3_pkg::CFG_W-1:0] dim_y_reg;
    logic [zz3_pkg::CFG_W-1:0] dim_z_reg;
    logic [DW-1:0]             dim_x;
    logic [DW-1:0]             dim_y;
    logic [DW-1:0]             dim_z;

    zz3_pkg::cmd_t       cmd;
    logic                take;
    logic                pop_done;
    zz3_pkg::cand_ctrl_t cand;
    logic [DW-1:0]       km1;
    logic [DW-1:0]       jm1;
    logic [DW-1:0]       ii;
    zz3_pkg::res_t       res;

    function automatic logic [DW-1:0] clamp_dim(input logic [zz3_pkg::CFG_W-1:0] v);
        logic [CLW-1:0] ext;
        logic [CLW-1:0] lim;
        ext = CLW'(v);
        lim = CLW'(MAX_DIM);
        priority if (ext == '0)
            return DW'(1);
        else if (ext > lim)
            return lim[DW-1:0];
        else
            return ext[DW-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_x_reg <= zz3_pkg::CFG_W'(1);
            dim_y_reg <= zz3_pkg::CFG_W'(1);
            dim_z_reg <= zz3_pkg::CFG_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                zz3_pkg::CFG_DIM_X: dim_x_reg <= cfg_data;
                zz3_pkg::CFG_DIM_Y: dim_y_reg <= cfg_data;
                zz3_pkg::CFG_DIM_Z: dim_z_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    assign dim_x    = clamp_dim(dim_x_reg);
    assign dim_y    = clamp_dim(dim_y_reg);
    assign dim_z    = clamp_dim(dim_z_reg);
    assign pop_done = pop && !empty;

    zz3_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .restart (restart),
        .full    (full),
        .take    (take),
        .cmd     (cmd)
    );

    zz3_walker #(.MAX_DIM(MAX_DIM)) u_walker
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .dim_x    (dim_x),
        .dim_y    (dim_y),
        .dim_z    (dim_z),
        .cmd      (cmd),
        .take     (take),
        .pop_done (pop_done),
        .cand     (cand),
        .km1      (km1),
        .jm1      (jm1),
        .ii       (ii)
    );

    zz3_index_unit #(.MAX_DIM(MAX_DIM)) u_index
    (
        .clk   (clk),
        .rst_n (rst_n),
        .dim_x (dim_x),
        .dim_y (dim_y),
        .cand  (cand),
        .km1   (km1),
        .jm1   (jm1),
        .ii    (ii),
        .res   (res)
    );

    zz3_result_queue u_result_queue
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .res          (res),
        .pop          (pop),
        .empty        (empty),
        .linear_index (linear_index),
        .last         (last)
    );

endmodule

// ----- rtl/core/zz3_front.sv -----
// ----------------------------------------------------------------------------
// zz3_front: request front end
// Accepts request words, classifies them as restart or next, and holds them
// in a short queue until the walker takes them.
// ----------------------------------------------------------------------------
module zz3_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic          restart,
    output logic          full,
    input  logic          take,
    output zz3_pkg::cmd_t cmd
);

    localparam int PW = (zz3_pkg::CQ_DEPTH > 1) ? $clog2(zz3_pkg::CQ_DEPTH) : 1;
    localparam int NW = $clog2(zz3_pkg::CQ_DEPTH + 1);

    zz3_pkg::cmd_kind_t kind_mem [zz3_pkg::CQ_DEPTH];

    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [NW-1:0] count_reg;
    logic [NW-1:0] count_next;
    logic          wr_en;
    logic          rd_en;

    assign full  = (count_reg == NW'(zz3_pkg::CQ_DEPTH));
    assign wr_en = push && !full;
    assign rd_en = take && (count_reg != '0);

    assign cmd.valid = (count_reg != '0);
    assign cmd.kind  = kind_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(zz3_pkg::CQ_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(zz3_pkg::CQ_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        count_next = count_reg + NW'(wr_en) - NW'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            kind_mem[wr_ptr_reg] <= restart ? zz3_pkg::CMD_RESTART : zz3_pkg::CMD_NEXT;
        end
    end

endmodule

// ----- rtl/core/zz3_walker.sv -----
// ----------------------------------------------------------------------------
// zz3_walker: zigzag walk sequencer
// Takes one request at a time, steps through candidates one per cycle along
// the serpentine fibers of each plane, skips those outside the volume and
// gives the index unit the first in-bounds one, or a blank word once done.
// ----------------------------------------------------------------------------
module zz3_walker
#(
    parameter int MAX_DIM = zz3_pkg::MAX_DIM_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [$clog2(MAX_DIM+1)-1:0]  dim_x,
    input  logic [$clog2(MAX_DIM+1)-1:0]  dim_y,
    input  logic [$clog2(MAX_DIM+1)-1:0]  dim_z,
    input  zz3_pkg::cmd_t                 cmd,
    output logic                          take,
    input  logic                          pop_done,
    output zz3_pkg::cand_ctrl_t           cand,
    output logic [$clog2(MAX_DIM+1)-1:0]  km1,
    output logic [$clog2(MAX_DIM+1)-1:0]  jm1,
    output logic [$clog2(MAX_DIM+1)-1:0]  ii
);

    localparam int DW  = $clog2(MAX_DIM + 1);
    localparam int LW  = $clog2(3 * MAX_DIM);
    localparam int FW  = LW + 1;
    localparam int CRW = LW + 3;
    localparam int CW  = $clog2(zz3_pkg::RQ_DEPTH + 1);

    localparam logic signed [CRW-1:0] S_ONE = CRW'(1);
    localparam logic signed [CRW-1:0] S_TWO = CRW'(2);
    localparam logic signed [FW:0]    F_ONE = (FW + 1)'(1);

    zz3_pkg::walk_state_t state_reg;
    zz3_pkg::walk_state_t state_next;
    zz3_pkg::dir_t        pdir_reg;
    zz3_pkg::dir_t        pdir_next;
    zz3_pkg::dir_t        fdir_reg;
    zz3_pkg::dir_t        fdir_next;
    logic [LW-1:0]        level_reg;
    logic [LW-1:0]        level_next;
    logic [FW-1:0]        fiber_reg;
    logic [FW-1:0]        fiber_next;
    logic [LW-1:0]        elem_reg;
    logic [LW-1:0]        elem_next;
    logic signed [CRW-1:0] ci_reg;
    logic signed [CRW-1:0] ci_next;
    logic signed [CRW-1:0] cj_reg;
    logic signed [CRW-1:0] cj_next;
    logic                 done_reg;
    logic                 done_next;
    logic [CW-1:0]        inflight_reg;
    logic [CW-1:0]        inflight_next;

    logic [LW-1:0]         end_level;
    logic                  past_end;
    logic signed [CRW-1:0] lvl_s;
    logic signed [CRW-1:0] ck;
    logic signed [CRW-1:0] ckm1;
    logic signed [CRW-1:0] cjm1;
    logic signed [CRW-1:0] xs;
    logic signed [CRW-1:0] ys;
    logic signed [CRW-1:0] zs;
    logic                  in_bounds;
    logic                  corner;
    logic                  credit_ok;

    zz3_pkg::dir_t         adv_pdir;
    zz3_pkg::dir_t         adv_fdir;
    logic [LW-1:0]         adv_level;
    logic [FW-1:0]         adv_fiber;
    logic [LW-1:0]         adv_elem;
    logic signed [CRW-1:0] adv_ci;
    logic signed [CRW-1:0] adv_cj;

    logic [LW-1:0]         elem_inc;
    logic signed [FW:0]    fsum;
    logic signed [FW:0]    two_l_m1;
    logic signed [CRW-1:0] fn_c;
    logic signed [CRW-1:0] lvl_inc_s;
    logic                  plane_end;

    assign end_level = LW'(dim_x) + LW'(dim_y) + LW'(dim_z) - LW'(2);
    assign past_end  = (level_reg > end_level);
    assign lvl_s     = $signed(CRW'(level_reg));
    assign ck        = lvl_s + S_TWO - ci_reg - cj_reg;
    assign ckm1      = ck - S_ONE;
    assign cjm1      = cj_reg - S_ONE;
    assign xs        = $signed(CRW'(dim_x));
    assign ys        = $signed(CRW'(dim_y));
    assign zs        = $signed(CRW'(dim_z));
    assign in_bounds = (ci_reg >= S_ONE) && (ci_reg <= xs) && (cj_reg >= S_ONE)
                    && (cj_reg <= ys) && (ck >= S_ONE) && (ck <= zs);
    assign corner    = (ci_reg == xs) && (cj_reg == ys) && (ck == zs);
    assign credit_ok = (inflight_reg < CW'(zz3_pkg::RQ_DEPTH));

    assign km1 = ckm1[DW-1:0];
    assign jm1 = cjm1[DW-1:0];
    assign ii  = ci_reg[DW-1:0];

    // step to the next candidate: along the fiber, to the next fiber, or to the next plane
    always_comb
    begin
        elem_inc  = elem_reg + LW'(1);
        fsum      = $signed({1'b0, fiber_reg})
                  + ((pdir_reg == zz3_pkg::DIR_FWD) ? F_ONE : -F_ONE);
        two_l_m1  = $signed({1'b0, level_reg, 1'b0}) - F_ONE;
        plane_end = (fsum < F_ONE) || (fsum > two_l_m1);
        fn_c      = CRW'(fsum);
        lvl_inc_s = lvl_s + S_ONE;

        adv_pdir  = pdir_reg;
        adv_fdir  = fdir_reg;
        adv_level = level_reg;
        adv_fiber = fiber_reg;
        adv_elem  = elem_inc;
        adv_ci    = (fdir_reg == zz3_pkg::DIR_FWD) ? ci_reg - S_ONE : ci_reg + S_ONE;
        adv_cj    = (fdir_reg == zz3_pkg::DIR_FWD) ? cj_reg - S_ONE : cj_reg + S_ONE;

        if (elem_inc > level_reg)
        begin
            adv_elem = LW'(1);
            if (plane_end)
            begin
                adv_level = level_reg + LW'(1);
                adv_fdir  = zz3_pkg::DIR_FWD;
                if (pdir_reg == zz3_pkg::DIR_FWD)
                begin
                    adv_pdir  = zz3_pkg::DIR_BWD;
                    adv_fiber = {level_reg, 1'b1};
                    adv_ci    = S_ONE;
                    adv_cj    = lvl_inc_s;
                end
                else
                begin
                    adv_pdir  = zz3_pkg::DIR_FWD;
                    adv_fiber = FW'(1);
                    adv_ci    = lvl_inc_s;
                    adv_cj    = S_ONE;
                end
            end
            else
            begin
                adv_fiber = fsum[FW-1:0];
                if (fdir_reg == zz3_pkg::DIR_BWD)
                begin
                    adv_fdir = zz3_pkg::DIR_FWD;
                    adv_ci   = lvl_s - (fn_c >>> 1);
                    adv_cj   = lvl_s + S_ONE - (lvl_s - (fn_c >>> 1));
                end
                else
                begin
                    adv_fdir = zz3_pkg::DIR_BWD;
                    if (fn_c <= lvl_s)
                    begin
                        adv_ci = lvl_s - fn_c + S_ONE;
                        adv_cj = S_ONE;
                    end
                    else
                    begin
                        adv_ci = S_ONE;
                        adv_cj = fn_c - lvl_s + S_ONE;
                    end
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pdir_next  = pdir_reg;
        fdir_next  = fdir_reg;
        level_next = level_reg;
        fiber_next = fiber_reg;
        elem_next  = elem_reg;
        ci_next    = ci_reg;
        cj_next    = cj_reg;
        done_next  = done_reg;
        take       = 1'b0;
        cand       = '0;

        unique case (state_reg)
            zz3_pkg::W_IDLE:
            begin
                if (cmd.valid && credit_ok)
                begin
                    take       = 1'b1;
                    state_next = zz3_pkg::W_WALK;
                    if (cmd.kind == zz3_pkg::CMD_RESTART)
                    begin
                        pdir_next  = zz3_pkg::DIR_FWD;
                        fdir_next  = zz3_pkg::DIR_FWD;
                        level_next = LW'(1);
                        fiber_next = FW'(1);
                        elem_next  = LW'(1);
                        ci_next    = S_ONE;
                        cj_next    = S_ONE;
                        done_next  = 1'b0;
                    end
                end
            end
            zz3_pkg::W_WALK:
            begin
                priority if (done_reg)
                begin
                    cand.valid = 1'b1;
                    cand.blank = 1'b1;
                    state_next = zz3_pkg::W_IDLE;
                end
                else if (past_end)
                begin
                    cand.valid = 1'b1;
                    cand.blank = 1'b1;
                    cand.last  = 1'b1;
                    done_next  = 1'b1;
                    state_next = zz3_pkg::W_IDLE;
                end
                else
                begin
                    pdir_next  = adv_pdir;
                    fdir_next  = adv_fdir;
                    level_next = adv_level;
                    fiber_next = adv_fiber;
                    elem_next  = adv_elem;
                    ci_next    = adv_ci;
                    cj_next    = adv_cj;
                    if (in_bounds)
                    begin
                        cand.valid = 1'b1;
                        cand.last  = corner;
                        done_next  = corner;
                        state_next = zz3_pkg::W_IDLE;
                    end
                end
            end
        endcase

        inflight_next = inflight_reg + CW'(cand.valid) - CW'(pop_done);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= zz3_pkg::W_IDLE;
            pdir_reg     <= zz3_pkg::DIR_FWD;
            fdir_reg     <= zz3_pkg::DIR_FWD;
            level_reg    <= LW'(1);
            fiber_reg    <= FW'(1);
            elem_reg     <= LW'(1);
            ci_reg       <= S_ONE;
            cj_reg       <= S_ONE;
            done_reg     <= 1'b0;
            inflight_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            pdir_reg     <= pdir_next;
            fdir_reg     <= fdir_next;
            level_reg    <= level_next;
            fiber_reg    <= fiber_next;
            elem_reg     <= elem_next;
            ci_reg       <= ci_next;
            cj_reg       <= cj_next;
            done_reg     <= done_next;
            inflight_reg <= inflight_next;
        end
    end

`ifndef SYNTH
    a_take_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> (state_reg == zz3_pkg::W_WALK))
        else $error("walker did not enter walk after taking a request");

    a_issue_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
        cand.valid |=> (state_reg == zz3_pkg::W_IDLE))
        else $error("walker kept walking after issuing a word");

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (inflight_reg <= CW'(zz3_pkg::RQ_DEPTH)))
        else $error("more words in flight than the result queue holds");
`endif

endmodule

// ----- rtl/core/zz3_index_unit.sv -----
// ----------------------------------------------------------------------------
// zz3_index_unit: linear index pipeline
// Two-stage multiply-add that turns an in-bounds position into its 1-based
// linear index ((k-1)*Y + (j-1))*X + i; a blank word gets index 0.
// ----------------------------------------------------------------------------
module zz3_index_unit
#(
    parameter int MAX_DIM = zz3_pkg::MAX_DIM_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [$clog2(MAX_DIM+1)-1:0]  dim_x,
    input  logic [$clog2(MAX_DIM+1)-1:0]  dim_y,
    input  zz3_pkg::cand_ctrl_t           cand,
    input  logic [$clog2(MAX_DIM+1)-1:0]  km1,
    input  logic [$clog2(MAX_DIM+1)-1:0]  jm1,
    input  logic [$clog2(MAX_DIM+1)-1:0]  ii,
    output zz3_pkg::res_t                 res
);

    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int TW = 2 * DW;
    localparam int IW = zz3_pkg::IDX_W;

    zz3_pkg::cand_ctrl_t s1_ctrl_reg;
    logic [TW-1:0]       s1_t_reg;
    logic [TW-1:0]       s1_t_next;
    logic [DW-1:0]       s1_i_reg;
    zz3_pkg::res_t       res_reg;
    zz3_pkg::res_t       res_next;

    assign s1_t_next = TW'(km1) * TW'(dim_y) + TW'(jm1);

    always_comb
    begin
        res_next.valid = s1_ctrl_reg.valid;
        res_next.last  = s1_ctrl_reg.last;
        res_next.index = s1_ctrl_reg.blank ? '0
                       : IW'(s1_t_reg) * IW'(dim_x) + IW'(s1_i_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctrl_reg <= '0;
            res_reg     <= '0;
        end
        else
        begin
            s1_ctrl_reg <= cand;
            res_reg     <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_t_reg <= s1_t_next;
        s1_i_reg <= ii;
    end

    assign res = res_reg;

endmodule

// ----- rtl/core/zz3_result_queue.sv -----
// ----------------------------------------------------------------------------
// zz3_result_queue: result output queue
// Holds finished result words until the consumer pops them, so the walker
// runs ahead of a stalled output.
// ----------------------------------------------------------------------------
module zz3_result_queue
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  zz3_pkg::res_t              res,
    input  logic                       pop,
    output logic                       empty,
    output logic [zz3_pkg::IDX_W-1:0]  linear_index,
    output logic                       last
);

    localparam int PW = (zz3_pkg::RQ_DEPTH > 1) ? $clog2(zz3_pkg::RQ_DEPTH) : 1;
    localparam int NW = $clog2(zz3_pkg::RQ_DEPTH + 1);

    logic [zz3_pkg::IDX_W-1:0] idx_mem  [zz3_pkg::RQ_DEPTH];
    logic                      last_mem [zz3_pkg::RQ_DEPTH];

    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [NW-1:0] count_reg;
    logic [NW-1:0] count_next;
    logic          rd_en;

    assign empty        = (count_reg == '0);
    assign rd_en        = pop && !empty;
    assign linear_index = idx_mem[rd_ptr_reg];
    assign last         = last_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (res.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(zz3_pkg::RQ_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(zz3_pkg::RQ_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        count_next = count_reg + NW'(res.valid) - NW'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            idx_mem[wr_ptr_reg]  <= res.index;
            last_mem[wr_ptr_reg] <= res.last;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (count_reg < NW'(zz3_pkg::RQ_DEPTH)))
        else $error("result word written into a full queue");
`endif

endmodule
